@@ rtl/tslb_pkg.sv @@
`default_nettype none

package tslb_pkg;

  // Default geometry of the ring.
  localparam int LINES_DEF    = 60;
  localparam int LINE_LEN_DEF = 80;

  // Port field widths.
  localparam int CMD_W    = 1;
  localparam int BYTE_W   = 8;
  localparam int ROW_W    = 6;
  localparam int COL_W    = 7;
  localparam int SHOWN_W  = 6;
  localparam int HEAD_W   = 6;
  localparam int PHASE_W  = 2;

  // Item commands.
  localparam logic [CMD_W-1:0] CMD_WRITE = 1'b0;
  localparam logic [CMD_W-1:0] CMD_READ  = 1'b1;

  // Console control characters.
  localparam logic [BYTE_W-1:0] CH_BS       = 8'h08;
  localparam logic [BYTE_W-1:0] CH_LF       = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR       = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_ESC      = 8'h1B;
  localparam logic [BYTE_W-1:0] CH_DIGIT0   = 8'h30;
  localparam logic [BYTE_W-1:0] CH_DIGIT9   = 8'h39;
  localparam logic [BYTE_W-1:0] CH_SEMI     = 8'h3B;
  localparam logic [BYTE_W-1:0] CH_LBRACKET = 8'h5B;
  localparam logic [BYTE_W-1:0] CH_NUL      = 8'h00;

  // Escape sequence phases.
  localparam logic [PHASE_W-1:0] PH_NORMAL = 2'd0;
  localparam logic [PHASE_W-1:0] PH_ESC    = 2'd1;
  localparam logic [PHASE_W-1:0] PH_CSI    = 2'd2;

endpackage

`default_nettype wire

@@ rtl/terminal_scrollback_line_buffer_core.sv @@
// A write transaction's result is registered in the cycle after acceptance. A read transaction
// passes the registered read of the line store and length memory, then the result register.
// Throughput: one write per cycle while the receiver takes each result; a read holds off
// the next transaction until its registered memory read has been passed to the result.
// Reset (synchronous, active low) clears the ring counters, cursor, escape phase and
// result valid at once; no clearing pass runs, since a character is shown only once written.
`default_nettype none

module terminal_scrollback_line_buffer_core #(
  parameter int LINES    = tslb_pkg::LINES_DEF,
  parameter int LINE_LEN = tslb_pkg::LINE_LEN_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [tslb_pkg::CMD_W-1:0]    in_command,
  input  wire logic [tslb_pkg::BYTE_W-1:0]   in_byte_in,
  input  wire logic                          in_end_of_write,
  input  wire logic [tslb_pkg::ROW_W-1:0]    in_view_row,
  input  wire logic [tslb_pkg::COL_W-1:0]    in_view_col,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [tslb_pkg::BYTE_W-1:0]   out_read_char,
  output logic      [tslb_pkg::SHOWN_W-1:0]  out_shown_lines,
  output logic      [tslb_pkg::HEAD_W-1:0]   out_current_line,
  output logic      [tslb_pkg::COL_W-1:0]    out_cursor_column,
  output logic      [tslb_pkg::PHASE_W-1:0]  out_escape_phase
);

  import tslb_pkg::*;

  localparam int LW  = $clog2(LINES);
  localparam int CW  = $clog2(LINE_LEN);
  localparam int AW  = $clog2(LINES * LINE_LEN);
  localparam int SHW = $clog2(LINES + 1);
  localparam int RW  = ((SHW > ROW_W) ? SHW : ROW_W) + 1;
  localparam int VW  = ((CW > COL_W) ? CW : COL_W) + 1;

  // Ring and cursor state.
  logic [LW-1:0]      head_r, head_nxt;
  logic               full_r, full_nxt;
  logic [CW-1:0]      col_r, col_nxt;
  logic [CW-1:0]      head_len_r, head_len_nxt;
  logic [PHASE_W-1:0] esc_r, esc_nxt;

  // Read in flight and result register.
  logic               rd_pend_r;
  logic               rd_hit_r;
  logic               rd_head_r;
  logic [CW-1:0]      rd_col_r;
  logic               out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0]  char_r, char_nxt;

  logic               in_acc, out_acc, wr_acc, rd_acc;
  logic               st_we, ln_we;
  logic [AW-1:0]      st_waddr, st_raddr;
  logic [BYTE_W-1:0]  st_q;
  logic [CW-1:0]      ln_q;
  logic [SHW-1:0]     shown_w;
  logic [LW-1:0]      start_w, idx_w;
  logic [RW-1:0]      sum_w;
  logic               row_ok, col_ok;
  logic [CW-1:0]      rd_col_w, cur_len;

  assign in_ready = !rd_pend_r && (!out_valid_r || out_ready);
  assign in_acc   = in_valid && in_ready;
  assign out_acc  = out_valid_r && out_ready;
  assign wr_acc   = in_acc && (in_command == CMD_WRITE);
  assign rd_acc   = in_acc && (in_command == CMD_READ);

  assign shown_w = full_r ? SHW'(LINES) : (SHW'(head_r) + SHW'(1));

  // Display row to ring index: once the ring has wrapped, the oldest line follows the head.
  always_comb begin
    start_w = '0;
    if (full_r) begin
      start_w = (head_r == LW'(LINES - 1)) ? '0 : head_r + LW'(1);
    end
    sum_w  = RW'(start_w) + RW'(in_view_row);
    idx_w  = (sum_w >= RW'(LINES)) ? LW'(sum_w - RW'(LINES)) : LW'(sum_w);
    row_ok = RW'(in_view_row) < RW'(shown_w);
    col_ok = VW'(in_view_col) < VW'(LINE_LEN);
  end

  assign rd_col_w = CW'(in_view_col);
  assign st_raddr = AW'(idx_w) * AW'(LINE_LEN) + AW'(rd_col_w);
  assign st_waddr = AW'(head_r) * AW'(LINE_LEN) + AW'(col_r);

  // Write transactions update the cursor state here.
  always_comb begin
    head_nxt     = head_r;
    full_nxt     = full_r;
    col_nxt      = col_r;
    head_len_nxt = head_len_r;
    esc_nxt      = esc_r;
    st_we        = 1'b0;
    ln_we        = 1'b0;
    if (wr_acc) begin
      unique case (esc_r)
        PH_ESC: begin
          esc_nxt = (in_byte_in == CH_LBRACKET) ? PH_CSI : PH_NORMAL;
        end
        PH_CSI: begin
          if (!(((in_byte_in >= CH_DIGIT0) && (in_byte_in <= CH_DIGIT9)) ||
                (in_byte_in == CH_SEMI))) begin
            esc_nxt = PH_NORMAL;
          end
        end
        default: begin
          priority if (in_byte_in == CH_CR) begin
            esc_nxt = esc_r;
          end else if (in_byte_in == CH_BS) begin
            if (col_r != '0) begin
              col_nxt = col_r - CW'(1);
              if (head_len_r > col_nxt) begin
                head_len_nxt = col_nxt;
              end
            end
          end else if (in_byte_in == CH_LF) begin
            // The finished line's length goes to memory; the new line starts empty.
            ln_we        = 1'b1;
            col_nxt      = '0;
            head_len_nxt = '0;
            if (head_r == LW'(LINES - 1)) begin
              head_nxt = '0;
              full_nxt = 1'b1;
            end else begin
              head_nxt = head_r + LW'(1);
            end
          end else if (in_byte_in == CH_ESC) begin
            esc_nxt = PH_ESC;
          end else begin
            if (col_r < CW'(LINE_LEN - 1)) begin
              // Cells past the shown length are never read, so the trailing zero is not stored.
              st_we   = 1'b1;
              col_nxt = col_r + CW'(1);
              if ((in_byte_in != CH_NUL) && (head_len_r == col_r)) begin
                head_len_nxt = col_r + CW'(1);
              end
            end
          end
        end
      endcase
      if (in_end_of_write) begin
        esc_nxt = PH_NORMAL;
      end
    end
  end

  // The head line's length lives in a register; the memory holds the lines left behind.
  assign cur_len = rd_head_r ? head_len_r : ln_q;

  always_comb begin
    out_valid_nxt = out_valid_r;
    char_nxt      = char_r;
    if (out_acc) begin
      out_valid_nxt = 1'b0;
    end
    if (wr_acc) begin
      out_valid_nxt = 1'b1;
      char_nxt      = CH_NUL;
    end else if (rd_pend_r) begin
      out_valid_nxt = 1'b1;
      char_nxt      = (rd_hit_r && (rd_col_r < cur_len)) ? st_q : CH_NUL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      full_r      <= 1'b0;
      col_r       <= '0;
      head_len_r  <= '0;
      esc_r       <= PH_NORMAL;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      full_r      <= full_nxt;
      col_r       <= col_nxt;
      head_len_r  <= head_len_nxt;
      esc_r       <= esc_nxt;
      rd_pend_r   <= rd_acc;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    char_r <= char_nxt;
    if (rd_acc) begin
      rd_hit_r  <= row_ok && col_ok;
      rd_head_r <= (idx_w == head_r);
      rd_col_r  <= rd_col_w;
    end
  end

  tslb_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (LINES * LINE_LEN)
  ) u_line_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (in_byte_in),
    .re    (rd_acc),
    .raddr (st_raddr),
    .rdata (st_q)
  );

  tslb_ram #(
    .WIDTH (CW),
    .DEPTH (LINES)
  ) u_line_len (
    .clk   (clk),
    .we    (ln_we),
    .waddr (head_r),
    .wdata (head_len_r),
    .re    (rd_acc),
    .raddr (idx_w),
    .rdata (ln_q)
  );

  assign out_valid         = out_valid_r;
  assign out_read_char     = char_r;
  assign out_shown_lines   = SHOWN_W'(shown_w);
  assign out_current_line  = HEAD_W'(head_r);
  assign out_cursor_column = COL_W'(col_r);
  assign out_escape_phase  = esc_r;

endmodule

`default_nettype wire

@@ rtl/tslb_ram.sv @@
`default_nettype none

module tslb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ tb/tslb_screen_checker.sv @@
`default_nettype none

module tslb_screen_checker (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  input  wire logic                         in_ready,
  input  wire logic [tslb_pkg::CMD_W-1:0]   in_command,
  input  wire logic [tslb_pkg::BYTE_W-1:0]  in_byte_in,
  input  wire logic                         in_end_of_write,
  input  wire logic [tslb_pkg::ROW_W-1:0]   in_view_row,
  input  wire logic [tslb_pkg::COL_W-1:0]   in_view_col,
  input  wire logic                         out_valid,
  input  wire logic                         out_ready,
  input  wire logic [tslb_pkg::BYTE_W-1:0]  out_read_char,
  input  wire logic [tslb_pkg::SHOWN_W-1:0] out_shown_lines,
  input  wire logic [tslb_pkg::HEAD_W-1:0]  out_current_line,
  input  wire logic [tslb_pkg::COL_W-1:0]   out_cursor_column,
  input  wire logic [tslb_pkg::PHASE_W-1:0] out_escape_phase,
  output int                                mismatch_count,
  output int                                pending_results
);
  timeunit 1ns;
  timeprecision 1ps;

  import tslb_pkg::*;

  localparam int ROWS = LINES_DEF;
  localparam int COLS = LINE_LEN_DEF;

  typedef struct packed {
    logic [BYTE_W-1:0]  read_char;
    logic [SHOWN_W-1:0] shown_lines;
    logic [HEAD_W-1:0]  current_line;
    logic [COL_W-1:0]   cursor_column;
    logic [PHASE_W-1:0] escape_phase;
  } line_status_t;

  logic [BYTE_W-1:0]  glyphs [ROWS*COLS];
  int                 line_len [ROWS];
  int                 head_row;
  int                 cursor;
  int                 rows_filled;
  logic [PHASE_W-1:0] esc_phase;
  int                 fail_total;
  line_status_t       expected_status_q [$];

  function automatic int rows_shown();
    return (rows_filled >= ROWS) ? ROWS : head_row + 1;
  endfunction

  function automatic void store_glyph(int col, logic [BYTE_W-1:0] v);
    if (col < COLS) glyphs[head_row*COLS + col] = v;
  endfunction

  function automatic void console_byte(logic [BYTE_W-1:0] b);
    int c;
    if (esc_phase == PH_ESC) begin
      esc_phase = (b == CH_LBRACKET) ? PH_CSI : PH_NORMAL;
    end else if (esc_phase == PH_CSI) begin
      // Parameters are digits and semicolons; anything else ends the sequence.
      if (!((b >= CH_DIGIT0 && b <= CH_DIGIT9) || b == CH_SEMI)) esc_phase = PH_NORMAL;
    end else if (b == CH_CR) begin
      // A carriage return leaves the line as it is.
    end else if (b == CH_BS) begin
      if (cursor > 0) begin
        cursor--;
        store_glyph(cursor, CH_NUL);
        if (line_len[head_row] > cursor) line_len[head_row] = cursor;
      end
    end else if (b == CH_LF) begin
      head_row = (head_row + 1) % ROWS;
      if (rows_filled < ROWS) rows_filled++;
      cursor = 0;
      store_glyph(0, CH_NUL);
      line_len[head_row] = 0;
    end else if (b == CH_ESC) begin
      esc_phase = PH_ESC;
    end else if (cursor < COLS - 1) begin
      c = cursor;
      store_glyph(c, b);
      cursor = c + 1;
      store_glyph(cursor, CH_NUL);
      // The shown length stops growing at the first zero byte of the line.
      if (b != CH_NUL && line_len[head_row] == c) line_len[head_row] = c + 1;
    end
  endfunction

  function automatic logic [BYTE_W-1:0] glyph_at(int row, int col);
    int start;
    int idx;
    if (row >= rows_shown() || col >= COLS) return '0;
    start = (rows_filled >= ROWS) ? (head_row + 1) % ROWS : 0;
    idx = (start + row) % ROWS;
    if (col >= line_len[idx]) return '0;
    return glyphs[idx*COLS + col];
  endfunction

  function automatic line_status_t predict_item(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] b,
                                                logic eow, logic [ROW_W-1:0] row,
                                                logic [COL_W-1:0] col);
    line_status_t s;
    s.read_char = '0;
    if (cmd == CMD_WRITE) begin
      console_byte(b);
      if (eow) esc_phase = PH_NORMAL;
    end else begin
      s.read_char = glyph_at(int'(row), int'(col));
    end
    s.shown_lines   = SHOWN_W'(rows_shown());
    s.current_line  = HEAD_W'(head_row);
    s.cursor_column = COL_W'(cursor);
    s.escape_phase  = esc_phase;
    return s;
  endfunction

  function automatic void check_field(string name, logic [BYTE_W-1:0] want,
                                      logic [BYTE_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
      fail_total++;
    end
  endfunction

  always @(posedge clk) begin
    line_status_t want;
    if (!rst_n) begin
      foreach (glyphs[i]) glyphs[i] = '0;
      foreach (line_len[i]) line_len[i] = 0;
      head_row    = 0;
      cursor      = 0;
      rows_filled = 0;
      esc_phase   = PH_NORMAL;
      fail_total  = 0;
      expected_status_q.delete();
    end else begin
      // Results always trail their transaction, so retire before predicting.
      if (out_valid && out_ready) begin
        if (expected_status_q.size() == 0) begin
          $display("%0t: result with no transaction pending, expected none, actual %0h",
                   $time, {out_read_char, out_shown_lines, out_current_line,
                           out_cursor_column, out_escape_phase});
          fail_total++;
        end else begin
          want = expected_status_q.pop_front();
          check_field("read_char", want.read_char, out_read_char);
          check_field("shown_lines", want.shown_lines, out_shown_lines);
          check_field("current_line", want.current_line, out_current_line);
          check_field("cursor_column", want.cursor_column, out_cursor_column);
          check_field("escape_phase", want.escape_phase, out_escape_phase);
        end
      end
      if (in_valid && in_ready) begin
        expected_status_q.push_back(predict_item(in_command, in_byte_in, in_end_of_write,
                                                 in_view_row, in_view_col));
      end
    end
    mismatch_count  <= fail_total;
    pending_results <= expected_status_q.size();
  end

endmodule

`default_nettype wire

@@ tb/terminal_scrollback_line_buffer_core_tb.sv @@
`default_nettype none

module terminal_scrollback_line_buffer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tslb_pkg::*;

  localparam int RANDOM_ITEMS = 600;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int HOLD_CYCLES  = 300;

  logic               clk             = 1'b0;
  logic               rst_n           = 1'b0;
  logic               in_valid        = 1'b0;
  logic [CMD_W-1:0]   in_command      = CMD_WRITE;
  logic [BYTE_W-1:0]  in_byte_in      = '0;
  logic               in_end_of_write = 1'b0;
  logic [ROW_W-1:0]   in_view_row     = '0;
  logic [COL_W-1:0]   in_view_col     = '0;
  logic               out_ready       = 1'b0;
  logic               in_ready;
  logic               out_valid;
  logic [BYTE_W-1:0]  out_read_char;
  logic [SHOWN_W-1:0] out_shown_lines;
  logic [HEAD_W-1:0]  out_current_line;
  logic [COL_W-1:0]   out_cursor_column;
  logic [PHASE_W-1:0] out_escape_phase;

  int mismatch_count;
  int pending_results;
  int cycle_count  = 0;
  int items_sent   = 0;
  int calm_left    = 0;
  bit hold_out_req = 1'b0;

  terminal_scrollback_line_buffer_core u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_command        (in_command),
    .in_byte_in        (in_byte_in),
    .in_end_of_write   (in_end_of_write),
    .in_view_row       (in_view_row),
    .in_view_col       (in_view_col),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_read_char     (out_read_char),
    .out_shown_lines   (out_shown_lines),
    .out_current_line  (out_current_line),
    .out_cursor_column (out_cursor_column),
    .out_escape_phase  (out_escape_phase)
  );

  tslb_screen_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_command        (in_command),
    .in_byte_in        (in_byte_in),
    .in_end_of_write   (in_end_of_write),
    .in_view_row       (in_view_row),
    .in_view_col       (in_view_col),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_read_char     (out_read_char),
    .out_shown_lines   (out_shown_lines),
    .out_current_line  (out_current_line),
    .out_cursor_column (out_cursor_column),
    .out_escape_phase  (out_escape_phase),
    .mismatch_count    (mismatch_count),
    .pending_results   (pending_results)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic int sender_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Presents one transaction from the falling edge and holds it until it is taken.
  task automatic offer_item(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] b,
                            input logic eow, input logic [ROW_W-1:0] row,
                            input logic [COL_W-1:0] col);
    int gap;
    @(negedge clk);
    in_valid        <= 1'b1;
    in_command      <= cmd;
    in_byte_in      <= b;
    in_end_of_write <= eow;
    in_view_row     <= row;
    in_view_col     <= col;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    gap = (calm_left > 0) ? 0 : sender_gap();
    if (calm_left > 0) calm_left--;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic put_byte(input logic [BYTE_W-1:0] b, input logic eow);
    offer_item(CMD_WRITE, b, eow, ROW_W'($urandom), COL_W'($urandom));
  endtask

  task automatic peek_cell(input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col);
    offer_item(CMD_READ, BYTE_W'($urandom), 1'($urandom), row, col);
  endtask

  // Receiver: runs of ready and stalls, plus one long hold-off on request.
  initial begin
    int r;
    int level;
    int run;
    forever begin
      @(negedge clk);
      r = $urandom_range(0, 99);
      if (hold_out_req) begin
        hold_out_req = 1'b0;
        level = 0;
        run   = HOLD_CYCLES;
      end else if (r < 50) begin
        level = 1;
        run   = $urandom_range(1, 8);
      end else if (r < 70) begin
        level = 1;
        run   = $urandom_range(30, 150);
      end else if (r < 92) begin
        level = 0;
        run   = $urandom_range(1, 3);
      end else begin
        level = 0;
        run   = $urandom_range(10, 40);
      end
      out_ready <= level[0];
      repeat (run - 1) @(negedge clk);
    end
  end

  initial begin
    int kind;
    int n;
    int k;
    int random_start;
    bit hold_done;
    logic [BYTE_W-1:0] ch;
    hold_done = 1'b0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty screen, zero byte, controls and escape handling.
    peek_cell(6'd0, 7'd0);
    put_byte(8'h41, 1'b0);
    put_byte(CH_NUL, 1'b0);
    put_byte(8'h42, 1'b0);
    peek_cell(6'd0, 7'd0);
    peek_cell(6'd0, 7'd1);
    peek_cell(6'd0, 7'd2);
    put_byte(CH_CR, 1'b0);
    put_byte(CH_BS, 1'b0);
    put_byte(8'hFF, 1'b0);
    put_byte(CH_LF, 1'b0);
    put_byte(CH_BS, 1'b0);
    put_byte(CH_ESC, 1'b0);
    put_byte(8'h78, 1'b0);
    put_byte(CH_ESC, 1'b0);
    put_byte(CH_LBRACKET, 1'b0);
    put_byte(8'h31, 1'b0);
    put_byte(CH_SEMI, 1'b0);
    put_byte(8'h6D, 1'b0);
    put_byte(CH_ESC, 1'b1);
    put_byte(8'h43, 1'b0);
    put_byte(CH_ESC, 1'b0);
    put_byte(CH_LBRACKET, 1'b1);
    put_byte(8'h44, 1'b0);
    peek_cell(6'h3F, 7'h7F);
    peek_cell(6'd1, 7'd0);

    random_start = items_sent;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) == 0) calm_left = $urandom_range(20, 60);
      // Let the receiver stall long while items keep coming, so the input backs up.
      if (!hold_done && items_sent - random_start > 150) begin
        hold_done    = 1'b1;
        hold_out_req = 1'b1;
        calm_left    = 80;
      end
      kind = $urandom_range(0, 99);
      if (kind < 35) begin
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(75, 90) : $urandom_range(1, 12);
        repeat (n) begin
          k = $urandom_range(0, 99);
          if (k < 5) ch = CH_BS;
          else if (k < 8) ch = CH_CR;
          else if (k < 11) ch = CH_NUL;
          else ch = BYTE_W'($urandom_range(8'h20, 8'h7E));
          put_byte(ch, $urandom_range(0, 19) == 0);
        end
        if ($urandom_range(0, 4) != 0) put_byte(CH_LF, 1'($urandom));
      end else if (kind < 50) begin
        repeat ($urandom_range(1, 3)) put_byte(CH_LF, 1'($urandom));
      end else if (kind < 65) begin
        put_byte(CH_ESC, $urandom_range(0, 9) == 0);
        if ($urandom_range(0, 3) == 0) begin
          put_byte(BYTE_W'($urandom), $urandom_range(0, 9) == 0);
        end else begin
          put_byte(CH_LBRACKET, $urandom_range(0, 9) == 0);
          repeat ($urandom_range(0, 4)) begin
            ch = ($urandom_range(0, 3) == 0) ? CH_SEMI
                                             : BYTE_W'($urandom_range(CH_DIGIT0, CH_DIGIT9));
            put_byte(ch, $urandom_range(0, 19) == 0);
          end
          put_byte(BYTE_W'($urandom_range(8'h40, 8'h7E)), 1'($urandom));
        end
      end else if (kind < 85) begin
        repeat ($urandom_range(1, 4)) begin
          peek_cell(($urandom_range(0, 9) < 7) ? ROW_W'($urandom_range(0, 59))
                                                : ROW_W'($urandom_range(0, 63)),
                    ($urandom_range(0, 9) < 8) ? COL_W'($urandom_range(0, 15))
                                                : COL_W'($urandom_range(0, 127)));
        end
      end else if (kind < 95) begin
        repeat ($urandom_range(1, 3)) put_byte(BYTE_W'($urandom), $urandom_range(0, 3) == 0);
      end else begin
        repeat ($urandom_range(1, 5)) put_byte(CH_BS, 1'b0);
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
